// ===== src/mpct_pkg.sv =====
// ---------------------------------------------------------------------------
// mpct_pkg
// Shared constants, types and helpers for the mouse packet cursor tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package mpct_pkg;

  // coordinate and field widths
  localparam int unsigned CoordBits  = 12;
  localparam int unsigned SumBits    = CoordBits + 2;
  localparam int unsigned RegBits    = 13;
  localparam int unsigned DeltaBits  = 9;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned CoordLimit = 1 << CoordBits;

  // flags byte bit positions
  localparam int unsigned FlagLeft  = 0;
  localparam int unsigned FlagSignX = 4;
  localparam int unsigned FlagSignY = 5;

  // reset screen size
  localparam logic [RegBits-1:0] ResetWidth  = RegBits'(640);
  localparam logic [RegBits-1:0] ResetHeight = RegBits'(480);

  // configuration register index
  typedef enum logic [0:0] {
    RegScreenWidth  = 1'b0,
    RegScreenHeight = 1'b1
  } mpct_reg_t;

  // position of the next byte within a packet
  typedef enum logic [1:0] {
    PosFlags = 2'd0,
    PosX     = 2'd1,
    PosY     = 2'd2,
    PosStray = 2'd3
  } mpct_bytepos_t;

  // completed packet from the assembler to the cursor stage
  typedef struct packed {
    logic                        emit;
    logic signed [DeltaBits-1:0] dx;
    logic signed [DeltaBits-1:0] dy;
    logic                        left;
  } mpct_pkt_t;

  // largest legal coordinate for a screen size register
  function automatic logic [CoordBits-1:0] coord_max(input logic [RegBits-1:0] r);
    logic [CoordBits-1:0] m;
    if (r == '0) begin
      m = '0;
    end else if (32'(r) > CoordLimit) begin
      m = '1;
    end else begin
      m = CoordBits'(r - 1'b1);
    end
    return m;
  endfunction

  // center coordinate for a screen size register
  function automatic logic [CoordBits-1:0] coord_center(input logic [RegBits-1:0] r);
    logic [CoordBits-1:0] c;
    if (r == '0) begin
      c = '0;
    end else if (32'(r) > CoordLimit) begin
      c = CoordBits'(CoordLimit >> 1);
    end else begin
      c = CoordBits'(r >> 1);
    end
    return c;
  endfunction

  // clamp a moved coordinate into 0 .. max
  function automatic logic [CoordBits-1:0] clamp_coord(input logic signed [SumBits-1:0] v,
                                                       input logic [CoordBits-1:0] max);
    logic [CoordBits-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > $signed({2'b00, max})) begin
      c = max;
    end else begin
      c = v[CoordBits-1:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/mpct_if.sv =====
// ---------------------------------------------------------------------------
// mpct_if
// Valid/ready channels for raw mouse bytes and cursor result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface mpct_byte_if;
  logic                               valid;
  logic                               ready;
  logic [mpct_pkg::ByteBits-1:0]      mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink   (input valid, input mouse_byte, output ready);
endinterface

interface mpct_cursor_if;
  logic                                valid;
  logic                                ready;
  logic [mpct_pkg::CoordBits-1:0]      cursor_x;
  logic [mpct_pkg::CoordBits-1:0]      cursor_y;
  logic signed [mpct_pkg::DeltaBits-1:0] delta_x;
  logic signed [mpct_pkg::DeltaBits-1:0] delta_y;
  logic                                moved;
  logic                                left_pressed;
  logic                                button_changed;

  modport source (output valid, output cursor_x, output cursor_y, output delta_x,
                  output delta_y, output moved, output left_pressed,
                  output button_changed, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input delta_x,
                  input delta_y, input moved, input left_pressed,
                  input button_changed, output ready);
endinterface

`default_nettype wire

// ===== src/mpct_packet_asm.sv =====
// ---------------------------------------------------------------------------
// mpct_packet_asm
// Input register and three-byte packet assembly with sign extension.
// ---------------------------------------------------------------------------
`default_nettype none

module mpct_packet_asm (
  input  wire logic              clk,
  input  wire logic              rst,
  mpct_byte_if.sink              mouse_in,
  input  wire logic              out_free,
  output mpct_pkg::mpct_pkt_t    pkt
);

  logic                            s1_valid;
  logic [mpct_pkg::ByteBits-1:0]   s1_byte;
  mpct_pkg::mpct_bytepos_t         byte_position;
  mpct_pkg::mpct_bytepos_t         byte_position_next;
  logic [mpct_pkg::ByteBits-1:0]   flags_hold;
  logic [mpct_pkg::ByteBits-1:0]   xdelta_hold;
  logic                            last_byte;
  logic                            go;

  // stray position completes the packet like the third byte
  assign last_byte = (byte_position == mpct_pkg::PosY) ||
                     (byte_position == mpct_pkg::PosStray);

  // registered byte leaves when it makes no item or the result slot is free
  assign go             = s1_valid && (!last_byte || out_free);
  assign mouse_in.ready = !s1_valid || go;

  // next byte position
  always_comb begin
    unique case (byte_position)
      mpct_pkg::PosFlags: byte_position_next = mpct_pkg::PosX;
      mpct_pkg::PosX:     byte_position_next = mpct_pkg::PosY;
      default:            byte_position_next = mpct_pkg::PosFlags;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (mouse_in.ready) begin
      s1_valid <= mouse_in.valid;
    end
    if (mouse_in.ready && mouse_in.valid) begin
      s1_byte <= mouse_in.mouse_byte;
    end
  end

  // packet holding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= mpct_pkg::PosFlags;
      flags_hold    <= '0;
      xdelta_hold   <= '0;
    end else if (go) begin
      byte_position <= byte_position_next;
      if (byte_position == mpct_pkg::PosFlags) begin
        flags_hold <= s1_byte;
      end
      if (byte_position == mpct_pkg::PosX) begin
        xdelta_hold <= s1_byte;
      end
    end
  end

  // completed packet with 9-bit signed deltas
  always_comb begin
    pkt.emit = go && last_byte;
    pkt.dx   = $signed({flags_hold[mpct_pkg::FlagSignX], xdelta_hold});
    pkt.dy   = $signed({flags_hold[mpct_pkg::FlagSignY], s1_byte});
    pkt.left = flags_hold[mpct_pkg::FlagLeft];
  end

endmodule

`default_nettype wire

// ===== src/mpct_cursor.sv =====
// ---------------------------------------------------------------------------
// mpct_cursor
// Screen size registers, cursor position update with clamping, button
// tracking and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mpct_cursor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [mpct_pkg::RegBits-1:0]  cfg_data,
  input  wire mpct_pkg::mpct_pkt_t           pkt,
  output logic                               out_free,
  mpct_cursor_if.source                      cursor_out
);

  logic [mpct_pkg::RegBits-1:0]        screen_width;
  logic [mpct_pkg::RegBits-1:0]        screen_height;
  logic [mpct_pkg::CoordBits-1:0]      pos_x;
  logic [mpct_pkg::CoordBits-1:0]      pos_y;
  logic [mpct_pkg::CoordBits-1:0]      pos_x_next;
  logic [mpct_pkg::CoordBits-1:0]      pos_y_next;
  logic                                left_last;
  logic                                out_valid;
  logic                                moved;
  logic signed [mpct_pkg::SumBits-1:0] sum_x;
  logic signed [mpct_pkg::SumBits-1:0] sum_y;
  logic                                take;
  mpct_pkg::mpct_reg_t                 reg_sel;

  assign reg_sel  = mpct_pkg::mpct_reg_t'(cfg_index);
  assign out_free = !out_valid || cursor_out.ready;
  assign take     = pkt.emit && out_free;

  // movement: x follows the mouse, y runs against it
  always_comb begin
    moved      = (pkt.dx != '0) || (pkt.dy != '0);
    sum_x      = $signed({2'b00, pos_x}) + mpct_pkg::SumBits'(pkt.dx);
    sum_y      = $signed({2'b00, pos_y}) - mpct_pkg::SumBits'(pkt.dy);
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    if (moved) begin
      pos_x_next = mpct_pkg::clamp_coord(sum_x, mpct_pkg::coord_max(screen_width));
      pos_y_next = mpct_pkg::clamp_coord(sum_y, mpct_pkg::coord_max(screen_height));
    end
  end

  // screen size, position and button state
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= mpct_pkg::ResetWidth;
      screen_height <= mpct_pkg::ResetHeight;
      pos_x         <= mpct_pkg::coord_center(mpct_pkg::ResetWidth);
      pos_y         <= mpct_pkg::coord_center(mpct_pkg::ResetHeight);
      left_last     <= 1'b0;
    end else if (cfg_wen) begin
      unique case (reg_sel)
        mpct_pkg::RegScreenWidth: begin
          screen_width <= cfg_data;
          pos_x        <= mpct_pkg::coord_center(cfg_data);
        end
        mpct_pkg::RegScreenHeight: begin
          screen_height <= cfg_data;
          pos_y         <= mpct_pkg::coord_center(cfg_data);
        end
        default: begin
        end
      endcase
    end else if (take) begin
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      left_last <= pkt.left;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (cursor_out.ready) begin
      out_valid <= 1'b0;
    end
    if (take) begin
      cursor_out.cursor_x       <= pos_x_next;
      cursor_out.cursor_y       <= pos_y_next;
      cursor_out.delta_x        <= pkt.dx;
      cursor_out.delta_y        <= pkt.dy;
      cursor_out.moved          <= moved;
      cursor_out.left_pressed   <= pkt.left;
      cursor_out.button_changed <= pkt.left != left_last;
    end
  end

  assign cursor_out.valid = out_valid;

endmodule

`default_nettype wire

// ===== src/mouse_packet_cursor_tracker.sv =====
// ---------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Gathers mouse bytes into three-byte packets and tracks a clamped cursor.
// The third byte goes into the input register, then the item is registered in
// the result register. Throughput: one byte per cycle while the result register
// is free; each register holds one item, and the result register sets stalls.
// Reset (synchronous, rst high): size 640x480, cursor at 320,240, packet
// position at the flags byte, no result pending. No clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module mouse_packet_cursor_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [mpct_pkg::RegBits-1:0]  cfg_data,
  mpct_byte_if.sink                          mouse_in,
  mpct_cursor_if.source                      cursor_out
);

  mpct_pkg::mpct_pkt_t pkt;
  logic                out_free;

  // packet assembly
  mpct_packet_asm u_asm (
    .clk      (clk),
    .rst      (rst),
    .mouse_in (mouse_in),
    .out_free (out_free),
    .pkt      (pkt)
  );

  // cursor update and result register
  mpct_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pkt        (pkt),
    .out_free   (out_free),
    .cursor_out (cursor_out)
  );

endmodule

`default_nettype wire

// ===== src/mpct_checker.sv =====
// ---------------------------------------------------------------------------
// mpct_checker
// Port-level checks for the mouse packet cursor tracker.
// ---------------------------------------------------------------------------
`default_nettype none

module mpct_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [mpct_pkg::CoordBits-1:0]       cursor_x,
  input wire logic [mpct_pkg::CoordBits-1:0]       cursor_y,
  input wire logic signed [mpct_pkg::DeltaBits-1:0] delta_x,
  input wire logic signed [mpct_pkg::DeltaBits-1:0] delta_y,
  input wire logic                                 moved,
  input wire logic                                 left_pressed,
  input wire logic                                 button_changed
);

  // no result item right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // moved flag agrees with the decoded deltas
  a_moved_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (moved == ((delta_x != '0) || (delta_y != '0))))
    else $error("moved flag disagrees with deltas");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_x) && $stable(cursor_y)
      && $stable(delta_x) && $stable(delta_y) && $stable(left_pressed)
      && $stable(button_changed)))
    else $error("stalled result changed");

  // a packet needs three bytes, so no result can come from one byte after reset
  a_no_early: assert property (@(posedge clk) rst |=> ##1 !out_valid)
    else $error("result item too soon after reset");

  // the input side is never stuck while the input register is empty after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (mouse_in.valid),
  .in_ready       (mouse_in.ready),
  .out_valid      (cursor_out.valid),
  .out_ready      (cursor_out.ready),
  .cursor_x       (cursor_out.cursor_x),
  .cursor_y       (cursor_out.cursor_y),
  .delta_x        (cursor_out.delta_x),
  .delta_y        (cursor_out.delta_y),
  .moved          (cursor_out.moved),
  .left_pressed   (cursor_out.left_pressed),
  .button_changed (cursor_out.button_changed)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Checks the mouse packet cursor tracker against a cycle-free predictor.
// Bytes from a queue go out on the byte channel, and every third byte is
// expected to produce one cursor item. Screen sizes cover the zero, minimum,
// saturation and full-scale cases. Random idling on both channels varies
// from phase to phase.
// ---------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpct_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseCount = 8;

  // expected cursor item
  typedef struct packed {
    logic [CoordBits-1:0]        x;
    logic [CoordBits-1:0]        y;
    logic signed [DeltaBits-1:0] dx;
    logic signed [DeltaBits-1:0] dy;
    logic                        moved;
    logic                        left;
    logic                        changed;
  } cursor_item_t;

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic [0:0]          cfg_index;
  logic [RegBits-1:0]  cfg_data;

  mpct_byte_if   mouse_in ();
  mpct_cursor_if cursor_out ();

  mouse_packet_cursor_tracker uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mouse_in   (mouse_in),
    .cursor_out (cursor_out)
  );

  // pending bytes and expected cursor items
  logic [ByteBits-1:0] mouse_byte_q[$];
  cursor_item_t        cursor_expect_q[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predictor state
  mpct_bytepos_t       pkt_pos = PosFlags;
  logic [ByteBits-1:0] flags_hold = '0;
  logic [ByteBits-1:0] x_hold = '0;
  logic                left_last = 1'b0;
  logic [RegBits-1:0]  width_reg = ResetWidth;
  logic [RegBits-1:0]  height_reg = ResetHeight;
  int                  cur_x = 320;
  int                  cur_y = 240;

  // usable screen extent: zero acts as one, large sizes saturate
  function automatic int screen_extent(input logic [RegBits-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > int'(CoordLimit)) return int'(CoordLimit);
    return int'(r);
  endfunction

  function automatic int pin_coord(input int v, input int extent);
    if (v < 0) return 0;
    if (v >= extent) return extent - 1;
    return v;
  endfunction

  // advance the predictor by one accepted byte
  function automatic void track_byte(input logic [ByteBits-1:0] b);
    cursor_item_t e;
    int dx;
    int dy;
    case (pkt_pos)
      PosFlags: begin
        flags_hold = b;
        pkt_pos = PosX;
      end
      PosX: begin
        x_hold = b;
        pkt_pos = PosY;
      end
      default: begin
        pkt_pos = PosFlags;
        dx = int'(x_hold) - (flags_hold[FlagSignX] ? 256 : 0);
        dy = int'(b) - (flags_hold[FlagSignY] ? 256 : 0);
        e.moved = (dx != 0) || (dy != 0);
        // screen y grows downward, mouse y grows upward
        if (e.moved) begin
          cur_x = pin_coord(cur_x + dx, screen_extent(width_reg));
          cur_y = pin_coord(cur_y - dy, screen_extent(height_reg));
        end
        e.left = flags_hold[FlagLeft];
        e.changed = (e.left != left_last);
        left_last = e.left;
        e.x = CoordBits'(cur_x);
        e.y = CoordBits'(cur_y);
        e.dx = DeltaBits'(dx);
        e.dy = DeltaBits'(dy);
        cursor_expect_q.push_back(e);
      end
    endcase
  endfunction

  function automatic string item_text(input cursor_item_t c);
    return $sformatf("x=%0d y=%0d dx=%0d dy=%0d moved=%0b left=%0b changed=%0b",
                     c.x, c.y, c.dx, c.dy, c.moved, c.left, c.changed);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // compare one accepted cursor item with the oldest expectation
  function automatic void check_cursor();
    cursor_item_t got;
    cursor_item_t want;
    got.x = cursor_out.cursor_x;
    got.y = cursor_out.cursor_y;
    got.dx = cursor_out.delta_x;
    got.dy = cursor_out.delta_y;
    got.moved = cursor_out.moved;
    got.left = cursor_out.left_pressed;
    got.changed = cursor_out.button_changed;
    if (cursor_expect_q.size() == 0) begin
      note_mismatch({"unexpected item ", item_text(got)});
    end else begin
      want = cursor_expect_q.pop_front();
      if (got !== want) begin
        note_mismatch({"expected ", item_text(want), " got ", item_text(got)});
      end
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      mouse_in.valid <= 1'b0;
    end else begin
      if (mouse_in.valid && mouse_in.ready) begin
        track_byte(mouse_in.mouse_byte);
      end
      if (!mouse_in.valid || mouse_in.ready) begin
        if (mouse_byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          mouse_in.valid <= 1'b1;
          mouse_in.mouse_byte <= mouse_byte_q.pop_front();
        end else begin
          mouse_in.valid <= 1'b0;
        end
      end
    end
  end

  // cursor monitor
  always @(posedge clk) begin
    if (rst) begin
      cursor_out.ready <= 1'b0;
    end else begin
      if (cursor_out.valid && cursor_out.ready) begin
        check_cursor();
      end
      cursor_out.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // wait until every byte is taken and every item has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (mouse_byte_q.size() != 0 || mouse_in.valid || cursor_expect_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // register write, block idle; a size write recenters that axis
  task automatic write_reg(input mpct_reg_t idx, input logic [RegBits-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == RegScreenWidth) begin
      width_reg = val;
      cur_x = screen_extent(val) / 2;
    end else begin
      height_reg = val;
      cur_y = screen_extent(val) / 2;
    end
  endtask

  // size for a phase: -1 small random screen, -2 any register value
  function automatic logic [RegBits-1:0] phase_size(input int code);
    if (code == -1) return RegBits'($urandom_range(300, 1));
    if (code == -2) return RegBits'($urandom_range(8191));
    return RegBits'(code);
  endfunction

  // random packet stream: mostly packets, some still ones, some stray bytes
  task automatic queue_random_bytes(input int count);
    int pushed;
    int pick;
    int mag;
    logic [ByteBits-1:0] flags;
    pushed = 0;
    while (pushed < count) begin
      pick = $urandom_range(99);
      flags = ByteBits'($urandom_range(255));
      if (pick < 8) begin
        // stray byte shifts the framing
        mouse_byte_q.push_back(flags);
        pushed += 1;
      end else if (pick < 25) begin
        // no movement, random buttons
        mouse_byte_q.push_back(flags & 8'hCF);
        mouse_byte_q.push_back('0);
        mouse_byte_q.push_back('0);
        pushed += 3;
      end else if (pick < 50) begin
        // small moves in either direction
        mouse_byte_q.push_back(flags);
        mag = $urandom_range(6);
        mouse_byte_q.push_back(flags[FlagSignX] ? ByteBits'(255 - mag) : ByteBits'(mag));
        mag = $urandom_range(6);
        mouse_byte_q.push_back(flags[FlagSignY] ? ByteBits'(255 - mag) : ByteBits'(mag));
        pushed += 3;
      end else begin
        mouse_byte_q.push_back(flags);
        mouse_byte_q.push_back(ByteBits'($urandom_range(255)));
        mouse_byte_q.push_back(ByteBits'($urandom_range(255)));
        pushed += 3;
      end
    end
  endtask

  // stimulus
  initial begin
    logic [ByteBits-1:0] directed_bytes[$];
    int ph_width[PhaseCount];
    int ph_height[PhaseCount];
    int ph_bytes[PhaseCount];
    int ph_src[PhaseCount];
    int ph_snk[PhaseCount];

    directed_bytes = '{
      8'h00, 8'h00, 8'h00,   // still, button up
      8'h01, 8'hFF, 8'hFF,   // press, largest positive moves, y clamps at top
      8'h30, 8'h00, 8'h00,   // release, most negative moves
      8'hFF, 8'hFF, 8'hFF,   // every flag bit, minus one on both axes
      8'h01, 8'hFF, 8'h00,   // push right
      8'h01, 8'hFF, 8'h00,   // push right into the edge
      8'h21, 8'h00, 8'hFF,   // y only, one step down
      8'h01, 8'h00, 8'h00    // button held, no movement
    };
    ph_width  = '{0, 1, 4096, 8191, 2, -1, 640, -2};
    ph_height = '{0, 1, 4096, 4097, 3, -1, 480, -2};
    ph_bytes  = '{70, 70, 150, 90, 60, 100, 100, 60};
    ph_src    = '{66, 0, 26, 0, 66, 0, 26, 66};
    ph_snk    = '{0, 66, 26, 0, 0, 66, 26, 0};

    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = RegScreenWidth;
    cfg_data = '0;
    mouse_in.valid = 1'b0;
    mouse_in.mouse_byte = '0;
    cursor_out.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed packets at the reset screen size
    @(negedge clk);
    foreach (directed_bytes[i]) mouse_byte_q.push_back(directed_bytes[i]);
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p % 2 == 0) begin
        write_reg(RegScreenWidth, phase_size(ph_width[p]));
        write_reg(RegScreenHeight, phase_size(ph_height[p]));
      end else begin
        write_reg(RegScreenHeight, phase_size(ph_height[p]));
        write_reg(RegScreenWidth, phase_size(ph_width[p]));
      end
      @(negedge clk);
      src_idle_pct = ph_src[p];
      snk_stall_pct = ph_snk[p];
      if (p == 2) begin
        // hold the sender until everything has drained, then resume
        queue_random_bytes(ph_bytes[p] / 2);
        wait_idle();
        @(negedge clk);
        queue_random_bytes(ph_bytes[p] / 2);
      end else begin
        queue_random_bytes(ph_bytes[p]);
      end
      wait_idle();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && cursor_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
